@@ rtl/rgar_pkg.sv @@
package rgar_pkg;

   localparam int PIX_PORT_BITS   = 16;
   localparam int SUM_OUT_BITS    = 32;
   localparam int ROI_WIDTH_BITS  = 11;
   localparam int ROI_HEIGHT_BITS = 16;
   localparam int CSR_INDEX_BITS  = 4;
   localparam int CSR_DATA_BITS   = 16;

   localparam logic [CSR_INDEX_BITS-1:0]  REG_ROI_WIDTH     = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0]  REG_ROI_HEIGHT    = 4'd1;
   localparam logic [ROI_WIDTH_BITS-1:0]  ROI_WIDTH_RESET   = 11'd1024;
   localparam logic [ROI_HEIGHT_BITS-1:0] ROI_HEIGHT_RESET  = 16'd1024;

   // position of the newest pixel inside the region
   typedef struct packed {
      logic r_ge1;
      logic r_ge2;
      logic c_ge1;
      logic c_ge2;
      logic c_last;
      logic r_last;
   } pos_flags_type;

   // rows then columns of the 3x3 window, row 2 is the newest row
   typedef logic [2:0][2:0][PIX_PORT_BITS-1:0] win_type;

   // strict maximum along at least one of four directions, neighbors
   // outside the region or the window are skipped
   function automatic logic is_peak(win_type w, int wr, int wc,
                                    logic up_ok, logic dn_ok,
                                    logic lf_ok, logic rt_ok);
      logic hit;
      logic seen;
      logic ok;
      logic in_img;
      int   dr;
      int   dc;
      int   nr;
      int   nc;
      hit = 1'b0;
      for (int d = 0; d < 4; d++) begin
         seen = 1'b0;
         ok   = 1'b1;
         for (int s = 0; s < 2; s++) begin
            case (d)
               0: begin
                  dr = 0;
                  dc = 1;
               end
               1: begin
                  dr = 1;
                  dc = 0;
               end
               2: begin
                  dr = 1;
                  dc = 1;
               end
               default: begin
                  dr = 1;
                  dc = -1;
               end
            endcase
            if (s == 0) begin
               dr = -dr;
               dc = -dc;
            end
            nr = wr + dr;
            nc = wc + dc;
            in_img = (dr >= 0 || up_ok) && (dr <= 0 || dn_ok) &&
                     (dc >= 0 || lf_ok) && (dc <= 0 || rt_ok);
            if (in_img && nr >= 0 && nr <= 2 && nc >= 0 && nc <= 2) begin
               seen = 1'b1;
               if (!(w[wr][wc] > w[nr][nc])) begin
                  ok = 1'b0;
               end
            end
         end
         if (seen && ok) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

@@ rtl/rgar_line_store.sv @@
module rgar_line_store import rgar_pkg::*; #(
   parameter int DEPTH     = 1024,
   parameter int DATA_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_BITS-1:0]     wr_data,
   output logic [DATA_BITS-1:0]     rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;
   logic [DATA_BITS-1:0] byp_data_ff;
   logic                 byp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      byp_data_ff <= wr_data;
   end

   // read and write of the same entry at one edge: pass the new data on
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (rd_en) begin
         byp_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_data_ff;

endmodule

@@ rtl/rgar_window.sv @@
module rgar_window import rgar_pkg::*; #(
   parameter int PIXEL_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  pos_flags_type             flags,
   input  logic [PIXEL_BITS-1:0]     pix,
   input  logic [2*PIXEL_BITS-1:0]   line_data,
   output logic [2*PIXEL_BITS-1:0]   wr_data,
   output logic [PIXEL_BITS+1:0]     peak_sum
);

   localparam int SUM_BITS = PIXEL_BITS + 2;

   logic [2:0][1:0][PIXEL_BITS-1:0] hist_ff;
   logic [2:0][2:0][PIXEL_BITS-1:0] win_in;
   logic [SUM_BITS-1:0]             peak_sum_ff;
   logic [SUM_BITS-1:0]             peak_sum_in;
   win_type                         wext;
   logic                            pk_a;
   logic                            pk_b;
   logic                            pk_c;
   logic                            pk_d;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_in[i][0] = hist_ff[i][0];
         win_in[i][1] = hist_ff[i][1];
      end
      win_in[0][2] = line_data[2*PIXEL_BITS-1:PIXEL_BITS];
      win_in[1][2] = line_data[PIXEL_BITS-1:0];
      win_in[2][2] = pix;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            wext[i][j] = PIX_PORT_BITS'(win_in[i][j]);
         end
      end
   end

   assign wr_data = {line_data[PIXEL_BITS-1:0], pix};

   always_comb begin
      pk_a = flags.r_ge1 && flags.c_ge1 &&
             is_peak(wext, 1, 1, flags.r_ge2, 1'b1, flags.c_ge2, 1'b1);
      pk_b = flags.r_ge1 && flags.c_last &&
             is_peak(wext, 1, 2, flags.r_ge2, 1'b1, flags.c_ge1, 1'b0);
      pk_c = flags.r_last && flags.c_ge1 &&
             is_peak(wext, 2, 1, flags.r_ge1, 1'b0, flags.c_ge2, 1'b1);
      pk_d = flags.r_last && flags.c_last &&
             is_peak(wext, 2, 2, flags.r_ge1, 1'b0, flags.c_ge1, 1'b0);
      peak_sum_in = (pk_a ? SUM_BITS'(win_in[1][1]) : '0) +
                    (pk_b ? SUM_BITS'(win_in[1][2]) : '0) +
                    (pk_c ? SUM_BITS'(win_in[2][1]) : '0) +
                    (pk_d ? SUM_BITS'(win_in[2][2]) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else if (step) begin
         for (int i = 0; i < 3; i++) begin
            hist_ff[i][0] <= win_in[i][1];
            hist_ff[i][1] <= win_in[i][2];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         peak_sum_ff <= peak_sum_in;
      end
   end

   assign peak_sum = peak_sum_ff;

endmodule

@@ rtl/ridge_gradient_area_roi.sv @@
// Ridge gradient area over a region of interest.
// req channel: one region pixel per transfer, raster order. The block sums
// every pixel and, separately, the pixels that are a strict maximum along
// at least one of four directions among their neighbors inside the region.
// rsp channel: one transfer per region, after its last pixel, carrying
// both sums modulo 2^32; no other pixel gives a result.
// csr channel: index 0 writes the region width, index 1 the height; any
// write to either restarts the frame. csr_ready is always high. Write only
// while no pixel is in flight.
// Throughput: one pixel per cycle while req_ready is high, set by the single line store
// memory, read at accept and written back in the next cycle.
// The last pixel passes stage 1, stage 2 and the result register before rsp_valid rises.
// The last pixel of a region is taken only once the previous result has
// left rsp and no earlier last pixel is in flight.
// A stalled rsp holds its result; other pixels keep flowing meanwhile.
// Reset sets width and height to 1024 and clears counters and sums; the
// line store needs no clearing, its entries are written before use.
module ridge_gradient_area_roi import rgar_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [PIX_PORT_BITS-1:0]   req_pixel,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [SUM_OUT_BITS-1:0]    rsp_local_max_sum,
   output logic [SUM_OUT_BITS-1:0]    rsp_total_sum,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_data
);

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int WID_BITS = $clog2(MAX_WIDTH + 1);
   localparam int WCMP     = (WID_BITS > ROI_WIDTH_BITS) ? WID_BITS : ROI_WIDTH_BITS;
   localparam int SUM_BITS = PIXEL_BITS + 2;

   logic [ROI_WIDTH_BITS-1:0]  roi_width_ff;
   logic [ROI_HEIGHT_BITS-1:0] roi_height_ff;
   logic                       restart;
   logic [WCMP-1:0]            width_ext;
   logic [WCMP-1:0]            width_eff;
   logic [COL_BITS-1:0]        col_last;
   logic [ROI_HEIGHT_BITS-1:0] row_last;

   logic [COL_BITS-1:0]        col_ff;
   logic [ROI_HEIGHT_BITS-1:0] row_ff;
   logic                       in_last;
   logic                       accept;
   logic [PIXEL_BITS-1:0]      pix;

   logic                       s1_valid_ff;
   pos_flags_type              s1_flags_ff;
   pos_flags_type              flags_in;
   logic [PIXEL_BITS-1:0]      s1_pix_ff;
   logic [COL_BITS-1:0]        s1_col_ff;

   logic                       s2_valid_ff;
   logic                       s2_last_ff;
   logic [PIXEL_BITS-1:0]      s2_pix_ff;
   logic [SUM_BITS-1:0]        peak_sum;

   logic [2*PIXEL_BITS-1:0]    line_rd;
   logic [2*PIXEL_BITS-1:0]    line_wr;

   logic [SUM_OUT_BITS-1:0]    max_acc_ff;
   logic [SUM_OUT_BITS-1:0]    tot_acc_ff;
   logic [SUM_OUT_BITS-1:0]    max_acc_in;
   logic [SUM_OUT_BITS-1:0]    tot_acc_in;
   logic                       rsp_valid_ff;
   logic [SUM_OUT_BITS-1:0]    rsp_max_ff;
   logic [SUM_OUT_BITS-1:0]    rsp_tot_ff;

   // configuration
   assign csr_ready = 1'b1;
   assign restart   = csr_valid && (csr_index == REG_ROI_WIDTH ||
                                    csr_index == REG_ROI_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         roi_width_ff  <= ROI_WIDTH_RESET;
         roi_height_ff <= ROI_HEIGHT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_ROI_WIDTH:  roi_width_ff  <= csr_data[ROI_WIDTH_BITS-1:0];
            REG_ROI_HEIGHT: roi_height_ff <= csr_data[ROI_HEIGHT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      width_ext = WCMP'(roi_width_ff);
      if (width_ext == '0) begin
         width_eff = WCMP'(1);
      end else if (width_ext > WCMP'(MAX_WIDTH)) begin
         width_eff = WCMP'(MAX_WIDTH);
      end else begin
         width_eff = width_ext;
      end
      col_last = COL_BITS'(width_eff - WCMP'(1));
      row_last = (roi_height_ff == '0) ? '0 : roi_height_ff - ROI_HEIGHT_BITS'(1);
   end

   // position counters and input side
   assign in_last   = (col_ff == col_last) && (row_ff == row_last);
   assign req_ready = !(in_last && (rsp_valid_ff || (s1_valid_ff && s1_flags_ff.c_last &&
                        s1_flags_ff.r_last) || (s2_valid_ff && s2_last_ff)));
   assign accept    = req_valid && req_ready;
   assign pix       = req_pixel[PIXEL_BITS-1:0];

   always_comb begin
      flags_in.r_ge1  = row_ff != '0;
      flags_in.r_ge2  = row_ff > ROI_HEIGHT_BITS'(1);
      flags_in.c_ge1  = col_ff != '0;
      flags_in.c_ge2  = col_ff > COL_BITS'(1);
      flags_in.c_last = col_ff == col_last;
      flags_in.r_last = row_ff == row_last;
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (col_ff == col_last) begin
            col_ff <= '0;
            row_ff <= in_last ? '0 : row_ff + ROI_HEIGHT_BITS'(1);
         end else begin
            col_ff <= col_ff + COL_BITS'(1);
         end
      end
   end

   // stage 1: line store read in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_flags_ff <= flags_in;
         s1_pix_ff   <= pix;
         s1_col_ff   <= col_ff;
      end
   end

   rgar_line_store #(
      .DEPTH     (MAX_WIDTH),
      .DATA_BITS (2 * PIXEL_BITS)
   ) u_line_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (line_wr),
      .rd_data (line_rd)
   );

   rgar_window #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .step      (s1_valid_ff),
      .flags     (s1_flags_ff),
      .pix       (s1_pix_ff),
      .line_data (line_rd),
      .wr_data   (line_wr),
      .peak_sum  (peak_sum)
   );

   // stage 2: accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_last_ff <= s1_flags_ff.c_last && s1_flags_ff.r_last;
         s2_pix_ff  <= s1_pix_ff;
      end
   end

   assign max_acc_in = max_acc_ff + SUM_OUT_BITS'(peak_sum);
   assign tot_acc_in = tot_acc_ff + SUM_OUT_BITS'(s2_pix_ff);

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         max_acc_ff <= '0;
         tot_acc_ff <= '0;
      end else if (s2_valid_ff) begin
         if (s2_last_ff) begin
            max_acc_ff <= '0;
            tot_acc_ff <= '0;
         end else begin
            max_acc_ff <= max_acc_in;
            tot_acc_ff <= tot_acc_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_valid_ff && s2_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && s2_last_ff) begin
         rsp_max_ff <= max_acc_in;
         rsp_tot_ff <= tot_acc_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_local_max_sum = rsp_max_ff;
   assign rsp_total_sum     = rsp_tot_ff;

endmodule

@@ rtl/rgar_checker.sv @@
module rgar_checker import rgar_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [PIX_PORT_BITS-1:0]   req_pixel,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [SUM_OUT_BITS-1:0]    rsp_local_max_sum,
   input  logic [SUM_OUT_BITS-1:0]    rsp_total_sum,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_data
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_local_max_sum) &&
      $stable(rsp_total_sum))
      else $error("rsp changed while stalled");

   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // a new result is preceded by a pixel transfer
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 3))
      else $error("result without a matching pixel transfer");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("csr write not taken");

endmodule

bind ridge_gradient_area_roi rgar_checker u_rgar_checker (.*);
